// ----- sv/pgr_pkg.sv -----
// ----------------------------------------------------------------------------
// pgr_pkg: shared types and constants
// Command codes, controller states, datapath micro-ops and sizes for the
// PageRank power iteration block.
// ----------------------------------------------------------------------------
`default_nettype none

package pgr_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 4096;
  localparam int FRAC_BITS    = 30;

  localparam int V_W   = 9;   // vertex counts 0..256
  localparam int VA_W  = 8;   // vertex index
  localparam int RA_W  = 9;   // row offset index 0..256
  localparam int EA_W  = 12;  // edge index
  localparam int OFS_W = 13;  // row offsets and edge counts
  localparam int RANK_W = 32;
  localparam int ACC_W = 40;  // sums of up to 256 ranks
  localparam int PROD_W = 56;
  localparam int DIV_W = 40;
  localparam int DSR_W = 13;
  localparam int CNT_W = 6;
  localparam int ROUND_W = 10;

  localparam logic [1:0] CFG_VCOUNT = 2'd0;
  localparam logic [1:0] CFG_DAMP   = 2'd1;
  localparam logic [1:0] CFG_TOL    = 2'd2;
  localparam logic [1:0] CFG_LIMIT  = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_RANK   = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_ROW  = 2'd0,
    OP_LOAD_EDGE = 2'd1,
    OP_RUN       = 2'd2,
    OP_READ      = 2'd3
  } in_op_e;

  typedef enum logic [4:0] {
    DP_NOP, DP_RD_ADDR, DP_EMIT_RD, DP_START1, DP_CAP1, DP_CAP2, DP_INITWR,
    DP_ROUND, DP_F0, DP_F1, DP_DACC, DP_BMUL, DP_BDIV, DP_BSET, DP_FILLN,
    DP_SSPAN, DP_SDIV, DP_SCAP, DP_E0, DP_E1, DP_E2, DP_UCLR, DP_U0, DP_U1,
    DP_CONV, DP_TOTCLR, DP_T0, DP_T1, DP_EMIT_RUN
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_INIT, ST_W1, ST_W2, ST_FILLR, ST_RCHK,
    ST_DF0, ST_DF1, ST_DF2, ST_BMUL, ST_BDIV, ST_BW, ST_FILLN,
    ST_SF0, ST_SF1, ST_SF2, ST_SDIV, ST_SW, ST_E0, ST_E1, ST_E2,
    ST_UCLR, ST_U0, ST_U1, ST_CCHK, ST_T0, ST_T1, ST_EMIT
  } ctrl_st_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic i_last;
    logic u_last;
    logic k_last;
    logic span_empty;
    logic at_limit;
    logic conv_ok;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/pgr_div.sv -----
// ----------------------------------------------------------------------------
// pgr_div: restoring divider
// One quotient bit per cycle; 40-bit dividend over a 13-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pgr_div
  import pgr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);

  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] rem_q, rem_d, dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DSR_W:0]   rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_sub = rem_sh - {1'b0, dsr_q};
    rem_d   = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    quo_d   = {quo_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- sv/pgr_dpath.sv -----
// ----------------------------------------------------------------------------
// pgr_dpath: datapath
// Graph and rank memories, configuration registers, counters, accumulators
// and the result registers, stepped by micro-ops from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pgr_dpath
  import pgr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             cmd_i,
  output dp_sts_t                  sts_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [11:0]         slot_i,
  input  wire logic [12:0]         load_value_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [31:0]         cfg_data_i,
  output logic                     done_o,
  output logic                     result_kind_o,
  output logic [RANK_W-1:0]        rank_value_o,
  output logic [RANK_W-1:0]        rank_total_o,
  output logic [ROUND_W-1:0]       rounds_done_o,
  output logic                     converged_flag_o
);

  // configuration
  logic [V_W-1:0]     vcount_q;
  logic [15:0]        damp_q;
  logic [31:0]        tol_q;
  logic [ROUND_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      damp_q   <= 16'd55706;
      tol_q    <= 32'd1074;
      limit_q  <= ROUND_W'(100);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VCOUNT: vcount_q <= cfg_data_i[V_W-1:0];
        CFG_DAMP:   damp_q   <= cfg_data_i[15:0];
        CFG_TOL:    tol_q    <= cfg_data_i;
        CFG_LIMIT:  limit_q  <= cfg_data_i[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  logic [V_W-1:0] n, n_m1;
  assign n    = (vcount_q > V_W'(MAX_VERTICES)) ? V_W'(MAX_VERTICES) : vcount_q;
  assign n_m1 = n - 1'b1;

  // memories
  logic [OFS_W-1:0]  row_mem  [MAX_VERTICES+1];
  logic [OFS_W-1:0]  edge_mem [MAX_EDGES];
  logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
  logic [RANK_W-1:0] next_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rank_vld_q;

  logic [RA_W-1:0]   row_raddr;
  logic [EA_W-1:0]   edge_raddr;
  logic [VA_W-1:0]   rank_raddr, next_raddr, rank_waddr, next_waddr;
  logic [RANK_W-1:0] rank_wdata, next_wdata;
  logic              row_we, edge_we, rank_we, next_we;
  logic [OFS_W-1:0]  row_rd_q, edge_rd_q;
  logic [RANK_W-1:0] rank_rd_q, next_rd_q;

  // counters and working registers
  logic [V_W-1:0]     u_q, i_q;
  logic [OFS_W-1:0]   k_q, s_q, e_q;
  logic [ROUND_W-1:0] round_q;
  logic               conv_q;
  logic [ACC_W-1:0]   dang_q, diff_q, total_q;
  logic [PROD_W-1:0]  prod_q;
  logic [RANK_W-1:0]  start_q, telep_q, base_q, share_q;
  logic [VA_W-1:0]    v_q;
  logic               vok_q;
  logic [11:0]        slot_q;

  // divider
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [DSR_W-1:0] div_dsr;

  pgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // clamp of a row offset to the edge memory size
  logic [OFS_W-1:0] row_clamp;
  assign row_clamp = (row_rd_q > OFS_W'(MAX_EDGES)) ? OFS_W'(MAX_EDGES) : row_rd_q;

  logic             span_empty;
  assign span_empty = row_clamp <= s_q;

  logic [16:0]        one_m_d;
  logic [30:0]        telep_dvd;
  logic [ACC_W:0]     base_sum;
  logic [RANK_W:0]    next_sum;
  logic [RANK_W-1:0]  abs_diff;
  logic [ACC_W:0]     total_sat;

  always_comb begin
    one_m_d   = 17'h10000 - {1'b0, damp_q};
    telep_dvd = {one_m_d, 14'd0};
    base_sum  = {9'd0, telep_q} + {1'b0, div_q};
    next_sum  = {1'b0, next_rd_q} + {1'b0, share_q};
    abs_diff  = (next_rd_q >= rank_rd_q) ? (next_rd_q - rank_rd_q) : (rank_rd_q - next_rd_q);
    total_sat = {1'b0, total_q};
  end

  // address and control muxing
  always_comb begin
    row_raddr  = u_q;
    rank_raddr = u_q[VA_W-1:0];
    next_raddr = i_q[VA_W-1:0];
    edge_raddr = k_q[EA_W-1:0];
    rank_we    = 1'b0;
    rank_waddr = i_q[VA_W-1:0];
    rank_wdata = start_q;
    next_we    = 1'b0;
    next_waddr = i_q[VA_W-1:0];
    next_wdata = base_q;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dsr    = {4'd0, n};
    row_we     = cmd_i.accept && (op_i == OP_LOAD_ROW) && (slot_i[11:9] == '0)
                 && (slot_i[8:0] <= 9'(MAX_VERTICES));
    edge_we    = cmd_i.accept && (op_i == OP_LOAD_EDGE);
    unique case (cmd_i.op)
      DP_RD_ADDR: rank_raddr = slot_q[VA_W-1:0];
      DP_START1: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(64'd1 << FRAC_BITS);
      end
      DP_CAP1: begin
        div_start = 1'b1;
        div_dvd   = {9'd0, telep_dvd};
      end
      DP_INITWR: rank_we = 1'b1;
      DP_F1: row_raddr = u_q + 1'b1;
      DP_BDIV: begin
        div_start = 1'b1;
        div_dvd   = prod_q[PROD_W-1:16];
      end
      DP_FILLN: next_we = 1'b1;
      DP_SDIV: begin
        div_start = 1'b1;
        div_dvd   = {8'd0, prod_q[47:16]};
        div_dsr   = e_q - s_q;
      end
      DP_E1: next_raddr = edge_rd_q[VA_W-1:0];
      DP_E2: begin
        next_we    = vok_q;
        next_waddr = v_q;
        next_wdata = next_sum[RANK_W] ? '1 : next_sum[RANK_W-1:0];
      end
      DP_U0, DP_T0: rank_raddr = i_q[VA_W-1:0];
      DP_U1: begin
        rank_we    = 1'b1;
        rank_wdata = next_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[slot_i[RA_W-1:0]] <= load_value_i;
    row_rd_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[slot_i] <= load_value_i;
    edge_rd_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
    rank_rd_q <= rank_mem[rank_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_rd_q <= next_mem[next_raddr];
  end

  // ranks never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_vld_q <= '0;
    end else if (rank_we) begin
      rank_vld_q[rank_waddr] <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      slot_q <= slot_i;
      if (op_i == OP_RUN) begin
        round_q <= '0;
        conv_q  <= 1'b0;
        total_q <= '0;
      end
    end
    unique case (cmd_i.op)
      DP_START1: u_q <= '0;
      DP_CAP1:   start_q <= div_q[RANK_W-1:0];
      DP_CAP2: begin
        telep_q <= div_q[RANK_W-1:0];
        i_q     <= '0;
      end
      DP_INITWR, DP_FILLN, DP_T0, DP_U0: ;
      DP_ROUND: begin
        round_q <= round_q + 1'b1;
        u_q     <= '0;
        dang_q  <= '0;
      end
      DP_F1: s_q <= row_clamp;
      DP_DACC: begin
        if (span_empty) dang_q <= dang_q + {8'd0, rank_rd_q};
        u_q <= u_q + 1'b1;
      end
      DP_BMUL: prod_q <= PROD_W'(damp_q) * PROD_W'(dang_q);
      DP_BSET: begin
        base_q <= (base_sum[ACC_W:RANK_W] != '0) ? '1 : base_sum[RANK_W-1:0];
        i_q    <= '0;
        u_q    <= '0;
      end
      DP_SSPAN: begin
        e_q    <= row_clamp;
        k_q    <= s_q;
        prod_q <= PROD_W'(damp_q) * PROD_W'(rank_rd_q);
        if (span_empty) u_q <= u_q + 1'b1;
      end
      DP_SCAP: share_q <= div_q[RANK_W-1:0];
      DP_E1: begin
        v_q   <= edge_rd_q[VA_W-1:0];
        vok_q <= edge_rd_q < {4'd0, n};
      end
      DP_E2: begin
        k_q <= k_q + 1'b1;
        if (k_q == e_q - 1'b1) u_q <= u_q + 1'b1;
      end
      DP_UCLR: begin
        i_q    <= '0;
        diff_q <= '0;
      end
      DP_U1: diff_q <= diff_q + {8'd0, abs_diff};
      DP_CONV: begin
        conv_q  <= 1'b1;
        total_q <= '0;
        i_q     <= '0;
      end
      DP_TOTCLR: begin
        total_q <= '0;
        i_q     <= '0;
      end
      DP_T1: total_q <= total_q + {8'd0, rank_rd_q};
      default: ;
    endcase
    if (cmd_i.op == DP_INITWR || cmd_i.op == DP_FILLN || cmd_i.op == DP_U1
        || cmd_i.op == DP_T1) begin
      i_q <= i_q + 1'b1;
    end
  end

  // result registers
  logic out_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= (cmd_i.op == DP_EMIT_RD) || (cmd_i.op == DP_EMIT_RUN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_EMIT_RD) begin
      result_kind_o    <= KIND_RANK;
      rank_value_o     <= ((slot_q[11:8] == '0) && rank_vld_q[slot_q[VA_W-1:0]])
                          ? rank_rd_q : '0;
      rank_total_o     <= '0;
      rounds_done_o    <= '0;
      converged_flag_o <= 1'b0;
    end else if (cmd_i.op == DP_EMIT_RUN) begin
      result_kind_o    <= KIND_STATUS;
      rank_value_o     <= '0;
      rank_total_o     <= (total_sat[ACC_W:RANK_W] != '0) ? '1 : total_q[RANK_W-1:0];
      rounds_done_o    <= round_q;
      converged_flag_o <= conv_q;
    end
  end

  assign done_o = out_vld_q;

  always_comb begin
    sts_o.n_zero     = (n == '0);
    sts_o.i_last     = (i_q == n_m1);
    sts_o.u_last     = (u_q == n_m1);
    sts_o.k_last     = (k_q == e_q - 1'b1);
    sts_o.span_empty = span_empty;
    sts_o.at_limit   = (round_q == limit_q);
    sts_o.conv_ok    = diff_q <= {8'd0, tol_q};
    sts_o.div_done   = div_done;
  end

endmodule

`default_nettype wire

// ----- sv/pgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// pgr_ctrl: sequencer
// Walks the load, read and run flows and issues one datapath micro-op a cycle, idling while it waits on the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pgr_ctrl
  import pgr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic [1:0] op_i,
  input  wire dp_sts_t  sts_i,
  output dp_cmd_t       cmd_o,
  output logic          busy_o
);

  ctrl_st_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else         st_q <= st_d;
  end

  always_comb begin
    st_d         = st_q;
    cmd_o.accept = 1'b0;
    cmd_o.op     = DP_NOP;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          unique case (op_i)
            OP_RUN:  st_d = sts_i.n_zero ? ST_EMIT : ST_INIT;
            OP_READ: st_d = ST_RD0;
            default: ;
          endcase
        end
      end
      ST_RD0: begin
        cmd_o.op = DP_RD_ADDR;
        st_d     = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.op = DP_EMIT_RD;
        st_d     = ST_IDLE;
      end
      ST_INIT: begin
        cmd_o.op = DP_START1;
        st_d     = ST_W1;
      end
      ST_W1: if (sts_i.div_done) begin
        cmd_o.op = DP_CAP1;
        st_d     = ST_W2;
      end
      ST_W2: if (sts_i.div_done) begin
        cmd_o.op = DP_CAP2;
        st_d     = ST_FILLR;
      end
      ST_FILLR: begin
        cmd_o.op = DP_INITWR;
        if (sts_i.i_last) st_d = ST_RCHK;
      end
      ST_RCHK: begin
        if (sts_i.at_limit) begin
          cmd_o.op = DP_TOTCLR;
          st_d     = ST_T0;
        end else begin
          cmd_o.op = DP_ROUND;
          st_d     = ST_DF0;
        end
      end
      // dangling mass
      ST_DF0: begin
        cmd_o.op = DP_F0;
        st_d     = ST_DF1;
      end
      ST_DF1: begin
        cmd_o.op = DP_F1;
        st_d     = ST_DF2;
      end
      ST_DF2: begin
        cmd_o.op = DP_DACC;
        st_d     = sts_i.u_last ? ST_BMUL : ST_DF0;
      end
      ST_BMUL: begin
        cmd_o.op = DP_BMUL;
        st_d     = ST_BDIV;
      end
      ST_BDIV: begin
        cmd_o.op = DP_BDIV;
        st_d     = ST_BW;
      end
      ST_BW: if (sts_i.div_done) begin
        cmd_o.op = DP_BSET;
        st_d     = ST_FILLN;
      end
      ST_FILLN: begin
        cmd_o.op = DP_FILLN;
        if (sts_i.i_last) st_d = ST_SF0;
      end
      // spread along edges
      ST_SF0: begin
        cmd_o.op = DP_F0;
        st_d     = ST_SF1;
      end
      ST_SF1: begin
        cmd_o.op = DP_F1;
        st_d     = ST_SF2;
      end
      ST_SF2: begin
        cmd_o.op = DP_SSPAN;
        if (!sts_i.span_empty) st_d = ST_SDIV;
        else                   st_d = sts_i.u_last ? ST_UCLR : ST_SF0;
      end
      ST_SDIV: begin
        cmd_o.op = DP_SDIV;
        st_d     = ST_SW;
      end
      ST_SW: if (sts_i.div_done) begin
        cmd_o.op = DP_SCAP;
        st_d     = ST_E0;
      end
      ST_E0: begin
        cmd_o.op = DP_E0;
        st_d     = ST_E1;
      end
      ST_E1: begin
        cmd_o.op = DP_E1;
        st_d     = ST_E2;
      end
      ST_E2: begin
        cmd_o.op = DP_E2;
        if (!sts_i.k_last)     st_d = ST_E0;
        else if (sts_i.u_last) st_d = ST_UCLR;
        else                   st_d = ST_SF0;
      end
      // commit new ranks and sum the change
      ST_UCLR: begin
        cmd_o.op = DP_UCLR;
        st_d     = ST_U0;
      end
      ST_U0: begin
        cmd_o.op = DP_U0;
        st_d     = ST_U1;
      end
      ST_U1: begin
        cmd_o.op = DP_U1;
        st_d     = sts_i.i_last ? ST_CCHK : ST_U0;
      end
      ST_CCHK: begin
        if (sts_i.conv_ok) begin
          cmd_o.op = DP_CONV;
          st_d     = ST_T0;
        end else begin
          st_d = ST_RCHK;
        end
      end
      ST_T0: begin
        cmd_o.op = DP_T0;
        st_d     = ST_T1;
      end
      ST_T1: begin
        cmd_o.op = DP_T1;
        if (sts_i.i_last) st_d = ST_EMIT;
        else              st_d = ST_T0;
      end
      ST_EMIT: begin
        cmd_o.op = DP_EMIT_RUN;
        st_d     = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign busy_o = (st_q != ST_IDLE);

endmodule

`default_nettype wire

// ----- sv/pagerank_power_iteration.sv -----
// ----------------------------------------------------------------------------
// pagerank_power_iteration: PageRank over a compressed-row graph
// Load row offsets and edge targets, run power iteration, read ranks back.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Loads keep
// busy_o low and give no result. A read holds busy_o high through ST_RD0
// and ST_RD1 and its result shows in the cycle after. A run holds busy_o
// high until its last state, ST_EMIT, and its result shows in the cycle
// after; on an empty graph busy_o is high for one cycle. The run's length
// is set by the shared divider, which the run waits on for each quotient,
// and by the graph and rank memories, which have one read port each. Each
// result shows for exactly one cycle with done_o; the receiver cannot
// stall, so it must take it then.
`default_nettype none

module pagerank_power_iteration
  import pgr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [11:0] slot_i,
  input  wire logic [12:0] load_value_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic             result_kind_o,
  output logic [31:0]      rank_value_o,
  output logic [31:0]      rank_total_o,
  output logic [9:0]       rounds_done_o,
  output logic             converged_flag_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pgr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  pgr_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .slot_i           (slot_i),
    .load_value_i     (load_value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .result_kind_o    (result_kind_o),
    .rank_value_o     (rank_value_o),
    .rank_total_o     (rank_total_o),
    .rounds_done_o    (rounds_done_o),
    .converged_flag_o (converged_flag_o)
  );

endmodule

`default_nettype wire
